// File: sv/lgs_pkg.sv
package lgs_pkg;

   typedef enum logic [1:0] {
      CMD_WRITE   = 2'd0,
      CMD_READ    = 2'd1,
      CMD_CLEAR   = 2'd2,
      CMD_ADVANCE = 2'd3
   } cmd_type;

   typedef struct packed {
      cmd_type    cmd;
      logic [4:0] col;
      logic [4:0] line;
      logic       alive_in;
   } req_type;

   typedef struct packed {
      logic alive_out;
      logic stable;
   } rsp_type;

   localparam logic [3:0] BIRTH_COUNT   = 4'd3;
   localparam logic [3:0] SURVIVE_COUNT = 4'd2;

endpackage

// File: sv/lgs_ram.sv
module lgs_ram #(
   parameter int DATA_WIDTH = 32,
   parameter int DEPTH      = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [DATA_WIDTH-1:0]    wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [DATA_WIDTH-1:0]    rd_data
);

   logic [DATA_WIDTH-1:0] mem_ff [DEPTH];
   logic [DATA_WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: sv/lgs_row_rule.sv
module lgs_row_rule
   import lgs_pkg::*;
#(
   parameter int GRID_WIDTH = 32
) (
   input  logic [GRID_WIDTH-1:0] row_above,
   input  logic [GRID_WIDTH-1:0] row_self,
   input  logic [GRID_WIDTH-1:0] row_below,
   output logic [GRID_WIDTH-1:0] row_next
);

   logic [GRID_WIDTH+1:0] pad_above;
   logic [GRID_WIDTH+1:0] pad_self;
   logic [GRID_WIDTH+1:0] pad_below;

   assign pad_above = {1'b0, row_above, 1'b0};
   assign pad_self  = {1'b0, row_self, 1'b0};
   assign pad_below = {1'b0, row_below, 1'b0};

   always_comb begin
      logic [3:0] count;
      for (int c = 0; c < GRID_WIDTH; c++) begin
         count = 4'(pad_above[c]) + 4'(pad_above[c+1]) + 4'(pad_above[c+2])
               + 4'(pad_self[c]) + 4'(pad_self[c+2])
               + 4'(pad_below[c]) + 4'(pad_below[c+1]) + 4'(pad_below[c+2]);
         row_next[c] = (count == BIRTH_COUNT)
                     || (row_self[c] && (count == SURVIVE_COUNT));
      end
   end

endmodule

// File: sv/life_generation_step.sv
// Game of Life (B3/S23) engine over a grid of GRID_HEIGHT rows by GRID_WIDTH
// columns; cells beyond the edges count as dead.
// Command channel: req_data is taken at a rising edge where start is high and
// busy is low. Commands: write a cell, read a cell, clear the grid, advance
// one generation.
// Result channel: every command gives exactly one result, on rsp_data for
// one cycle while rsp_strobe is high. The receiver cannot stall it.
// Sequencing: a write or read first reads the row from the grid memory, then
// writes it back or reports; a clear drops the per-row valid flags at once,
// and a generation is one sweep over the grid memory with a three-row window,
// rows written back two rows behind the read pointer. For a write, read or
// generation the result appears in the same cycle that busy falls; the next
// command may be given in that same cycle.
// Reset: synchronous, active high; all cells read as dead afterwards, with
// no clearing pass.
module life_generation_step
   import lgs_pkg::*;
#(
   parameter int GRID_WIDTH  = 32,
   parameter int GRID_HEIGHT = 32
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   input  req_type req_data,
   output logic    busy,
   output logic    rsp_strobe,
   output rsp_type rsp_data
);

   localparam int ROW_W  = $clog2(GRID_HEIGHT);
   localparam int STEP_W = $clog2(GRID_HEIGHT + 2);

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_ACCESS = 3'b010,
      ST_GEN    = 3'b100
   } state_type;

   state_type               state_ff;
   cmd_type                 cmd_ff;
   logic [4:0]              col_ff;
   logic                    alive_ff;
   logic                    in_range_ff;
   logic [ROW_W-1:0]        line_addr_ff;
   logic [STEP_W-1:0]       step_ff;
   logic [GRID_WIDTH-1:0]   top_ff;
   logic [GRID_WIDTH-1:0]   mid_ff;
   logic                    stable_ff;
   logic [GRID_HEIGHT-1:0]  row_valid_ff;
   logic                    rd_valid_ff;
   logic                    rsp_strobe_ff;
   rsp_type                 rsp_data_ff;

   logic                    accept;
   logic                    req_in_range;
   logic [ROW_W+4:0]        line_wide;
   logic [ROW_W-1:0]        req_addr;
   logic [ROW_W-1:0]        rd_addr;
   logic [GRID_WIDTH-1:0]   rd_data;
   logic [GRID_WIDTH-1:0]   rd_row;
   logic [GRID_WIDTH-1:0]   incoming;
   logic [GRID_WIDTH-1:0]   cell_mask;
   logic [GRID_WIDTH-1:0]   modified_row;
   logic [GRID_WIDTH-1:0]   next_row;
   logic [STEP_W-1:0]       gen_wr_step;
   logic                    gen_write;
   logic                    last_step;
   logic                    wr_en;
   logic [ROW_W-1:0]        wr_addr;
   logic [GRID_WIDTH-1:0]   wr_data;

   assign accept       = start && !busy;
   assign busy         = (state_ff != ST_IDLE);
   assign req_in_range = (32'(req_data.col) < GRID_WIDTH)
                      && (32'(req_data.line) < GRID_HEIGHT);
   assign line_wide    = {{ROW_W{1'b0}}, req_data.line};
   assign req_addr     = line_wide[ROW_W-1:0];

   assign rd_addr  = (state_ff == ST_IDLE) ? req_addr : step_ff[ROW_W-1:0];
   assign rd_row   = rd_valid_ff ? rd_data : '0;
   assign incoming = (step_ff <= STEP_W'(GRID_HEIGHT)) ? rd_row : '0;

   assign cell_mask    = GRID_WIDTH'(1) << col_ff;
   assign modified_row = alive_ff ? (rd_row | cell_mask) : (rd_row & ~cell_mask);

   assign gen_wr_step = step_ff - STEP_W'(2);
   assign gen_write   = (state_ff == ST_GEN) && (step_ff >= STEP_W'(2));
   assign last_step   = (step_ff == STEP_W'(GRID_HEIGHT + 1));

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = line_addr_ff;
      wr_data = modified_row;
      case (state_ff)
         ST_ACCESS: begin
            wr_en = (cmd_ff == CMD_WRITE) && in_range_ff;
         end
         ST_GEN: begin
            wr_en   = gen_write;
            wr_addr = gen_wr_step[ROW_W-1:0];
            wr_data = next_row;
         end
         default: begin
            wr_en = 1'b0;
         end
      endcase
   end

   lgs_ram #(
      .DATA_WIDTH (GRID_WIDTH),
      .DEPTH      (GRID_HEIGHT)
   ) u_grid (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   lgs_row_rule #(
      .GRID_WIDTH (GRID_WIDTH)
   ) u_rule (
      .row_above (top_ff),
      .row_self  (mid_ff),
      .row_below (incoming),
      .row_next  (next_row)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         row_valid_ff  <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= 1'b0;
         if (wr_en) begin
            row_valid_ff[wr_addr] <= 1'b1;
         end
         case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  case (req_data.cmd)
                     CMD_WRITE, CMD_READ: begin
                        state_ff <= ST_ACCESS;
                     end
                     CMD_CLEAR: begin
                        row_valid_ff  <= '0;
                        rsp_strobe_ff <= 1'b1;
                     end
                     default: begin
                        state_ff <= ST_GEN;
                     end
                  endcase
               end
            end
            ST_ACCESS: begin
               state_ff      <= ST_IDLE;
               rsp_strobe_ff <= 1'b1;
            end
            ST_GEN: begin
               if (last_step) begin
                  state_ff      <= ST_IDLE;
                  rsp_strobe_ff <= 1'b1;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      rd_valid_ff <= row_valid_ff[rd_addr];
      case (state_ff)
         ST_IDLE: begin
            cmd_ff       <= req_data.cmd;
            col_ff       <= req_data.col;
            alive_ff     <= req_data.alive_in;
            in_range_ff  <= req_in_range;
            line_addr_ff <= req_addr;
            step_ff      <= '0;
            top_ff       <= '0;
            mid_ff       <= '0;
            stable_ff    <= 1'b1;
            rsp_data_ff  <= '0;
         end
         ST_ACCESS: begin
            rsp_data_ff.alive_out <= (cmd_ff == CMD_READ) && in_range_ff
                                  && |(rd_row & cell_mask);
            rsp_data_ff.stable    <= 1'b0;
         end
         ST_GEN: begin
            step_ff <= step_ff + STEP_W'(1);
            if (step_ff != '0) begin
               top_ff <= mid_ff;
               mid_ff <= incoming;
            end
            if (gen_write && (next_row != mid_ff)) begin
               stable_ff <= 1'b0;
            end
            rsp_data_ff.alive_out <= 1'b0;
            rsp_data_ff.stable    <= stable_ff && !(gen_write && (next_row != mid_ff));
         end
         default: begin
            rsp_data_ff <= '0;
         end
      endcase
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_data_ff;

endmodule

// File: tb/sv/life_generation_step_test.sv
module life_generation_step_test
   import lgs_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int GRID_WIDTH    = 32;
   localparam int GRID_HEIGHT   = 32;
   localparam int ITEM_TARGET   = 1350;
   localparam int CYCLE_LIMIT   = 400000;
   localparam int REPORT_LIMIT  = 10;
   localparam int DIRECTED_ROWS = 25;

   typedef struct {
      req_type cmd_item;
      bit      typed;
      rsp_type want;
   } directed_row_type;

   logic    clock    = 1'b0;
   logic    reset    = 1'b1;
   logic    start    = 1'b0;
   req_type req_data = '0;
   logic    busy;
   logic    rsp_strobe;
   rsp_type rsp_data;

   bit [GRID_WIDTH-1:0] life_grid [GRID_HEIGHT];
   rsp_type awaited_results [$];
   int items_sent     = 0;
   int mismatch_count = 0;
   int cycle_count    = 0;

   directed_row_type directed_table [DIRECTED_ROWS] = '{
      '{'{CMD_READ,    5'd0,  5'd0,  1'b0}, 1'b1, '{1'b0, 1'b0}},
      '{'{CMD_READ,    5'd31, 5'd31, 1'b1}, 1'b1, '{1'b0, 1'b0}},
      '{'{CMD_ADVANCE, 5'd0,  5'd0,  1'b0}, 1'b1, '{1'b0, 1'b1}},
      '{'{CMD_WRITE,   5'd0,  5'd0,  1'b1}, 1'b1, '{1'b0, 1'b0}},
      '{'{CMD_READ,    5'd0,  5'd0,  1'b0}, 1'b1, '{1'b1, 1'b0}},
      '{'{CMD_WRITE,   5'd31, 5'd31, 1'b1}, 1'b1, '{1'b0, 1'b0}},
      '{'{CMD_READ,    5'd31, 5'd31, 1'b0}, 1'b1, '{1'b1, 1'b0}},
      '{'{CMD_WRITE,   5'd31, 5'd0,  1'b1}, 1'b1, '{1'b0, 1'b0}},
      '{'{CMD_WRITE,   5'd0,  5'd31, 1'b1}, 1'b1, '{1'b0, 1'b0}},
      '{'{CMD_ADVANCE, 5'd31, 5'd31, 1'b1}, 1'b0, '{1'b0, 1'b0}},
      '{'{CMD_READ,    5'd0,  5'd0,  1'b1}, 1'b0, '{1'b0, 1'b0}},
      '{'{CMD_CLEAR,   5'd31, 5'd31, 1'b1}, 1'b1, '{1'b0, 1'b0}},
      '{'{CMD_WRITE,   5'd10, 5'd0,  1'b1}, 1'b0, '{1'b0, 1'b0}},
      '{'{CMD_WRITE,   5'd11, 5'd0,  1'b1}, 1'b0, '{1'b0, 1'b0}},
      '{'{CMD_WRITE,   5'd12, 5'd0,  1'b1}, 1'b0, '{1'b0, 1'b0}},
      '{'{CMD_ADVANCE, 5'd0,  5'd0,  1'b0}, 1'b0, '{1'b0, 1'b0}},
      '{'{CMD_READ,    5'd11, 5'd1,  1'b0}, 1'b0, '{1'b0, 1'b0}},
      '{'{CMD_WRITE,   5'd30, 5'd30, 1'b1}, 1'b0, '{1'b0, 1'b0}},
      '{'{CMD_WRITE,   5'd31, 5'd30, 1'b1}, 1'b0, '{1'b0, 1'b0}},
      '{'{CMD_WRITE,   5'd30, 5'd31, 1'b1}, 1'b0, '{1'b0, 1'b0}},
      '{'{CMD_WRITE,   5'd31, 5'd31, 1'b1}, 1'b0, '{1'b0, 1'b0}},
      '{'{CMD_ADVANCE, 5'd0,  5'd0,  1'b0}, 1'b0, '{1'b0, 1'b0}},
      '{'{CMD_WRITE,   5'd31, 5'd31, 1'b0}, 1'b0, '{1'b0, 1'b0}},
      '{'{CMD_READ,    5'd31, 5'd31, 1'b0}, 1'b0, '{1'b0, 1'b0}},
      '{'{CMD_ADVANCE, 5'd0,  5'd0,  1'b0}, 1'b0, '{1'b0, 1'b0}}
   };

   life_generation_step #(
      .GRID_WIDTH (GRID_WIDTH),
      .GRID_HEIGHT(GRID_HEIGHT)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .req_data  (req_data),
      .busy      (busy),
      .rsp_strobe(rsp_strobe),
      .rsp_data  (rsp_data)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   function automatic bit cell_live(int r, int c);
      if (r < 0 || r >= GRID_HEIGHT || c < 0 || c >= GRID_WIDTH)
         return 1'b0;
      return life_grid[r][c];
   endfunction

   function automatic bit step_generation();
      bit [GRID_WIDTH-1:0] next_rows [GRID_HEIGHT];
      int  count;
      bit  unchanged;
      unchanged = 1'b1;
      for (int r = 0; r < GRID_HEIGHT; r++) begin
         for (int c = 0; c < GRID_WIDTH; c++) begin
            count = 0;
            for (int dr = -1; dr <= 1; dr++)
               for (int dc = -1; dc <= 1; dc++)
                  if (dr != 0 || dc != 0)
                     count += cell_live(r + dr, c + dc);
            if (life_grid[r][c])
               next_rows[r][c] = (count == SURVIVE_COUNT || count == BIRTH_COUNT);
            else
               next_rows[r][c] = (count == BIRTH_COUNT);
         end
         if (next_rows[r] != life_grid[r])
            unchanged = 1'b0;
      end
      life_grid = next_rows;
      return unchanged;
   endfunction

   function automatic rsp_type life_apply(req_type cmd_item);
      rsp_type result;
      result = '0;
      case (cmd_item.cmd)
         CMD_WRITE: begin
            if (cmd_item.col < GRID_WIDTH && cmd_item.line < GRID_HEIGHT)
               life_grid[cmd_item.line][cmd_item.col] = cmd_item.alive_in;
         end
         CMD_READ: begin
            result.alive_out = cell_live(cmd_item.line, cmd_item.col);
         end
         CMD_CLEAR: begin
            foreach (life_grid[r])
               life_grid[r] = '0;
         end
         default: begin
            result.stable = step_generation();
         end
      endcase
      return result;
   endfunction

   function automatic req_type pack_cmd(cmd_type cmd, int col, int line, bit alive);
      req_type cmd_item;
      cmd_item.cmd      = cmd;
      cmd_item.col      = 5'(col);
      cmd_item.line     = 5'(line);
      cmd_item.alive_in = alive;
      return cmd_item;
   endfunction

   task automatic send_cmd(input req_type cmd_item, input bit typed = 1'b0,
                           input rsp_type want = '0);
      rsp_type predicted;
      int      idle_pct;
      idle_pct = (items_sent < 450) ? 36 : ((items_sent < 900) ? 59 : 0);
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start    <= 1'b1;
      req_data <= cmd_item;
      do @(posedge clock); while (busy);
      predicted = life_apply(cmd_item);
      awaited_results.push_back(typed ? want : predicted);
      items_sent++;
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_strobe) begin
         if (awaited_results.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT)
               $display("unexpected result: alive_out=%0b stable=%0b",
                        rsp_data.alive_out, rsp_data.stable);
         end else begin
            want = awaited_results.pop_front();
            if (rsp_data.alive_out !== want.alive_out || rsp_data.stable !== want.stable) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_LIMIT)
                  $display({"result mismatch: expected alive_out=%0b stable=%0b, ",
                            "got alive_out=%0b stable=%0b"},
                           want.alive_out, want.stable, rsp_data.alive_out, rsp_data.stable);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   initial begin
      int x0;
      int y0;
      int span;
      int density;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_table[i])
         send_cmd(directed_table[i].cmd_item, directed_table[i].typed,
                  directed_table[i].want);

      while (items_sent < ITEM_TARGET) begin
         if ($urandom_range(3) != 0)
            send_cmd(pack_cmd(CMD_CLEAR, $urandom_range(31), $urandom_range(31),
                              $urandom_range(1)));
         span    = $urandom_range(3, 16);
         x0      = $urandom_range(GRID_WIDTH - 1);
         y0      = $urandom_range(GRID_HEIGHT - 1);
         density = $urandom_range(30, 70);
         repeat ($urandom_range(6, 40))
            send_cmd(pack_cmd(CMD_WRITE, (x0 + $urandom_range(span - 1)) % GRID_WIDTH,
                              (y0 + $urandom_range(span - 1)) % GRID_HEIGHT,
                              $urandom_range(99) < density));
         repeat ($urandom_range(1, 6)) begin
            send_cmd(pack_cmd(CMD_ADVANCE, $urandom_range(31), $urandom_range(31),
                              $urandom_range(1)));
            repeat ($urandom_range(0, 3))
               send_cmd(pack_cmd(CMD_READ, (x0 + $urandom_range(span)) % GRID_WIDTH,
                                 (y0 + $urandom_range(span)) % GRID_HEIGHT,
                                 $urandom_range(1)));
         end
         if ($urandom_range(4) == 0)
            repeat ($urandom_range(1, 5))
               send_cmd(pack_cmd(cmd_type'($urandom_range(3)), $urandom_range(31),
                                 $urandom_range(31), $urandom_range(1)));
      end

      start <= 1'b0;
      while (awaited_results.size() != 0)
         @(posedge clock);
      repeat (GRID_HEIGHT + 4) @(posedge clock);
      if (mismatch_count == 0 && awaited_results.size() == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
